/* rtl/fctr_pkg.sv */
// ----------------------------------------------------------------------------
// fctr_pkg
// shared types and constants for the firmware call trap and exception return
// ----------------------------------------------------------------------------
package fctr_pkg;

   localparam int unsigned ReqDataWidth = 160;
   localparam int unsigned RspDataWidth = 104;
   localparam int unsigned OffWidth     = 22;
   localparam int unsigned SkipWidth    = 18;

   localparam logic [9:0] RomWindow  = 10'h2FF;
   localparam logic [9:0] KernWindow = 10'h200;

   localparam logic [OffWidth-1:0] OffRefill    = 22'h000000;
   localparam logic [OffWidth-1:0] OffRefillAlt = 22'h000170;
   localparam logic [OffWidth-1:0] OffGeneral   = 22'h000180;
   localparam logic [OffWidth-1:0] OffIntr      = 22'h000200;
   localparam logic [OffWidth-1:0] OffExit      = 22'h001C40;
   localparam logic [OffWidth-1:0] OffLoadExec  = 22'h001D20;
   localparam logic [OffWidth-1:0] OffModLoad   = 22'h002D10;
   localparam logic [OffWidth-1:0] OffModExec   = 22'h002D80;
   localparam logic [OffWidth-1:0] OffDmaReg    = 22'h001008;

   localparam int unsigned ExlBit = 1;
   localparam logic [4:0]  CodeIntr = 5'd0;

   typedef struct packed {
      logic [31:0] arg0;
      logic [31:0] return_addr;
      logic [31:0] cause_in;
      logic [31:0] status_in;
      logic [31:0] fetch_addr;
   } req_word_type;

   typedef struct packed {
      logic        ret_value;
      logic        write_ret;
      logic        halt;
      logic [31:0] cause_out;
      logic [31:0] status_out;
      logic [31:0] next_pc;
      logic        redirect;
      logic        trapped;
   } rsp_word_type;

endpackage

/* rtl/fctr_decode.sv */
// ----------------------------------------------------------------------------
// fctr_decode
// maps a fetch address to a firmware offset and works out the trap result
// ----------------------------------------------------------------------------
module fctr_decode (
   input  fctr_pkg::req_word_type req,
   output fctr_pkg::rsp_word_type rsp
);
   import fctr_pkg::*;

   logic                in_win;
   logic [OffWidth-1:0] off;
   logic                exl;
   logic [31:0]         status_clr;
   logic [31:0]         cause_clr;
   logic [31:0]         pc_skip;
   logic [31:0]         epc_next;

   assign in_win = (req.fetch_addr[31:22] == RomWindow) ||
                   (req.fetch_addr[31:22] == KernWindow);
   assign off    = req.fetch_addr[OffWidth-1:0];
   assign exl    = req.status_in[ExlBit];

   assign status_clr = req.status_in & ~(32'h1 << ExlBit);
   assign cause_clr  = {req.cause_in[31:16],
                        req.cause_in[15:8] & ~req.status_in[15:8],
                        req.cause_in[7:0]};
   assign pc_skip    = req.fetch_addr + 32'd8;
   assign epc_next   = req.return_addr + 32'd4;

   always_comb begin
      rsp            = '0;
      rsp.status_out = req.status_in;
      rsp.cause_out  = req.cause_in;
      if (in_win) begin
         priority if (off == OffRefill || off == OffRefillAlt) begin
            if (exl) begin
               rsp.trapped    = 1'b1;
               rsp.redirect   = 1'b1;
               rsp.status_out = status_clr;
               rsp.next_pc    = req.return_addr;
            end
         end else if (off == OffGeneral) begin
            if (exl) begin
               rsp.trapped    = 1'b1;
               rsp.redirect   = 1'b1;
               rsp.status_out = status_clr;
               if (req.cause_in[6:2] == CodeIntr) begin
                  rsp.cause_out = cause_clr;
                  rsp.next_pc   = req.return_addr;
               end else begin
                  rsp.next_pc   = epc_next;
               end
            end
         end else if (off == OffIntr) begin
            if (exl) begin
               rsp.trapped    = 1'b1;
               rsp.redirect   = 1'b1;
               rsp.status_out = status_clr;
               rsp.cause_out  = cause_clr;
               rsp.next_pc    = req.return_addr;
            end
         end else if (off == OffExit) begin
            rsp.trapped = 1'b1;
            rsp.halt    = 1'b1;
         end else if (off == OffLoadExec) begin
            rsp.trapped  = 1'b1;
            rsp.redirect = 1'b1;
            rsp.next_pc  = req.arg0;
         end else if (off == OffModLoad || off == OffModExec) begin
            rsp.trapped   = 1'b1;
            rsp.redirect  = 1'b1;
            rsp.write_ret = 1'b1;
            rsp.ret_value = 1'b1;
            rsp.next_pc   = pc_skip;
         end else if (off == OffDmaReg) begin
            rsp.trapped   = 1'b1;
            rsp.redirect  = 1'b1;
            rsp.write_ret = 1'b1;
            rsp.next_pc   = pc_skip;
         end else if (off[OffWidth-1:SkipWidth] == '0) begin
            rsp.trapped  = 1'b1;
            rsp.redirect = 1'b1;
            rsp.next_pc  = pc_skip;
         end else begin
            rsp.trapped  = 1'b0;
         end
      end
   end

endmodule

/* rtl/firmware_call_trap_and_exception_return.sv */
// ----------------------------------------------------------------------------
// firmware_call_trap_and_exception_return
// traps fetches into the firmware windows: exception return, library call
// skips, program jumps and halt
//
//   channel | dir | handshake            | word
//   req     | in  | req_tvalid/tready    | fetch, status, cause, epc, arg0
//   rsp     | out | rsp_tvalid/tready    | trap decision and updated state
//
// an accepted req word goes through the input register and the decode into
// the result register; one word per cycle while rsp_tready is high
// reset clears both valid flags; no other state
// a stalled rsp holds the result register; the input register still takes
// one word, then req_tready drops, so at most two words are in flight
// ----------------------------------------------------------------------------
module firmware_call_trap_and_exception_return (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fetch_addr, status_in, cause_in, return_addr, arg0
   input  logic [fctr_pkg::ReqDataWidth-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // trapped, redirect, next_pc, status_out, cause_out, halt, write_ret,
   // ret_value, zero padding
   output logic [fctr_pkg::RspDataWidth-1:0]     rsp_tdata
);
   import fctr_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type dec_word;
   logic         out_load;
   logic         in_load;

   assign out_load   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || out_load;
   assign in_load    = req_tvalid && req_tready;

   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && !rsp_tready);

   fctr_decode u_decode (
      .req (in_word_ff),
      .rsp (dec_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_word_ff <= req_word_type'(req_tdata);
      end
      if (out_load) begin
         out_word_ff <= dec_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - $bits(rsp_word_type)){1'b0}}, out_word_ff};

endmodule
